FILE: hw/rtl/acs_pkg.sv
`timescale 1ns / 1ps

package acs_pkg;

  localparam int unsigned CH_W       = 3;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned LEVEL_W    = 18;
  localparam int unsigned VALUE_W    = 7;
  localparam int unsigned ALPHA_W    = 9;
  localparam int unsigned THR_W      = 7;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned SCALE_SH   = 3;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;

  localparam int unsigned CHANNELS_DEFAULT = 8;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(64);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SMOOTH = 2'd0,
    FUNC_CHECK  = 2'd1,
    FUNC_SEED   = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    REG_ALPHA = 1'b0,
    REG_THR   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [VALUE_W-1:0] last;
  } entry_t;

endpackage

FILE: hw/rtl/acs_in_if.sv
`timescale 1ns / 1ps

interface acs_in_if;
  logic                          valid;
  logic                          ready;
  logic [acs_pkg::CH_W-1:0]      channel;
  logic [acs_pkg::SAMPLE_W-1:0]  raw_sample;
  logic [acs_pkg::FUNC_W-1:0]    func;

  modport source (output valid, output channel, output raw_sample, output func, input ready);
  modport sink   (input valid, input channel, input raw_sample, input func, output ready);
endinterface

FILE: hw/rtl/acs_out_if.sv
`timescale 1ns / 1ps

interface acs_out_if;
  logic                          valid;
  logic                          ready;
  logic [acs_pkg::VALUE_W-1:0]   level_value;
  logic                          changed;

  modport source (output valid, output level_value, output changed, input ready);
  modport sink   (input valid, input level_value, input changed, output ready);
endinterface

FILE: hw/rtl/analog_channel_smoother.sv
`timescale 1ns / 1ps

// channel  dir  handshake       payload
// in_i     in   valid / ready   channel, raw_sample, func
// out_o    out  valid / ready   level_value, changed
// apb      in   psel / penable  paddr, pwdata, prdata (pready tied high)
//
// one item per cycle sustained while the output is taken; the state ram is
// read at the edge that takes the item, the next cycle does the ema
// multiply-add and write back, and the result sits in the output register
// from the edge after that until taken
// reset clears the channel valid bits at once, so no clearing pass is needed;
// an entry never written reads as zero
// a stalled output holds the compute stage, which re-reads its entry from the
// ram each cycle; a write that lands while the next item reads is forwarded
module analog_channel_smoother #(
  parameter int unsigned CHANNELS = acs_pkg::CHANNELS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  acs_in_if.sink                      in_i,
  acs_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acs_pkg::APB_AW-1:0]  paddr,
  input  logic [acs_pkg::APB_DW-1:0]  pwdata,
  output logic [acs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // channel number widened so it can be compared and cut to the ram index
  localparam int unsigned XW = ((AW > acs_pkg::CH_W) ? AW : acs_pkg::CH_W) + 1;
  localparam int unsigned EW = $bits(acs_pkg::entry_t);

  // ---------------- configuration registers ----------------
  logic [acs_pkg::ALPHA_W-1:0] alpha_q;
  logic [acs_pkg::THR_W-1:0]   thr_q;
  logic                        cfg_wr;
  acs_pkg::reg_e               reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = acs_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= acs_pkg::ALPHA_RESET;
      thr_q   <= acs_pkg::THR_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        acs_pkg::REG_ALPHA: alpha_q <= pwdata[acs_pkg::ALPHA_W-1:0];
        acs_pkg::REG_THR:   thr_q   <= pwdata[acs_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      acs_pkg::REG_ALPHA: prdata = acs_pkg::APB_DW'(alpha_q);
      acs_pkg::REG_THR:   prdata = acs_pkg::APB_DW'(thr_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic                         en;        // compute stage may move on
  logic                         s1_vld_q;
  logic [AW-1:0]                s1_addr_q;
  logic                         s1_inr_q;  // channel is below CHANNELS
  logic [acs_pkg::SAMPLE_W-1:0] s1_sample_q;
  acs_pkg::func_e               s1_func_q;
  logic                         byp_q;
  acs_pkg::entry_t              byp_data_q;
  logic [CHANNELS-1:0]          vld_q;

  logic                         out_vld_q;
  logic [acs_pkg::VALUE_W-1:0]  out_value_q;
  logic                         out_changed_q;

  logic [XW-1:0]                in_ch_x;
  logic [AW-1:0]                in_addr;
  logic                         in_inr;
  logic                         accept;
  logic [AW-1:0]                rd_addr;

  logic                         wr_en;
  acs_pkg::entry_t              wr_data;
  logic [EW-1:0]                ram_rdata;

  assign en      = !out_vld_q || out_o.ready;
  assign in_i.ready = en;
  assign accept  = in_i.valid && en;
  assign in_ch_x = XW'(in_i.channel);
  assign in_addr = in_ch_x[AW-1:0];
  assign in_inr  = (in_ch_x < XW'(CHANNELS));
  // on a stall keep re-reading the held entry so the ram output stays current
  assign rd_addr = en ? in_addr : s1_addr_q;

  acs_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------- compute stage ----------------
  acs_pkg::entry_t              cur;
  logic [acs_pkg::ALPHA_W-1:0]  a_sat;
  logic [acs_pkg::LEVEL_W-1:0]  s_q8;
  logic signed [acs_pkg::LEVEL_W:0]   delta;
  logic signed [acs_pkg::LEVEL_W+acs_pkg::ALPHA_W+1:0] prod;
  logic signed [acs_pkg::LEVEL_W+acs_pkg::ALPHA_W+1:0] prod_sh;
  logic [acs_pkg::LEVEL_W+2:0]  lvl_sum;
  logic [acs_pkg::LEVEL_W-1:0]  new_level;
  logic [acs_pkg::VALUE_W-1:0]  scaled;
  logic [acs_pkg::VALUE_W-1:0]  ch_diff;
  logic                         wr_req;
  logic [acs_pkg::VALUE_W-1:0]  res_value;
  logic                         res_changed;

  always_comb begin
    if (byp_q) begin
      cur = byp_data_q;
    end else if (vld_q[s1_addr_q]) begin
      cur = acs_pkg::entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // level' = level + floor(alpha * (sample<<8 - level) / 256), same as the
  // weighted sum of both terms truncated
  assign a_sat   = alpha_q[acs_pkg::ALPHA_W-1] ? acs_pkg::ALPHA_ONE : alpha_q;
  assign s_q8    = {s1_sample_q, {acs_pkg::FRAC_W{1'b0}}};
  assign delta   = $signed({1'b0, s_q8}) - $signed({1'b0, cur.level});
  assign prod    = $signed({1'b0, a_sat}) * delta;
  assign prod_sh = prod >>> acs_pkg::FRAC_W;
  assign lvl_sum = (acs_pkg::LEVEL_W+3)'({3'b000, cur.level}) + prod_sh[acs_pkg::LEVEL_W+2:0];
  assign new_level = lvl_sum[acs_pkg::LEVEL_W-1:0];

  assign scaled  = s1_sample_q[acs_pkg::SAMPLE_W-1:acs_pkg::SCALE_SH];
  assign ch_diff = (scaled >= cur.last) ? (scaled - cur.last) : (cur.last - scaled);

  always_comb begin
    wr_req      = 1'b0;
    wr_data     = cur;
    res_value   = cur.last;
    res_changed = 1'b0;
    case (s1_func_q)
      acs_pkg::FUNC_SMOOTH: begin
        wr_req        = 1'b1;
        wr_data.level = new_level;
        wr_data.last  = new_level[acs_pkg::LEVEL_W-1 -: acs_pkg::VALUE_W];
        res_value     = new_level[acs_pkg::LEVEL_W-1 -: acs_pkg::VALUE_W];
      end
      acs_pkg::FUNC_CHECK: begin
        if (ch_diff >= thr_q) begin
          wr_req       = 1'b1;
          wr_data.last = scaled;
          res_value    = scaled;
          res_changed  = 1'b1;
        end
      end
      acs_pkg::FUNC_SEED: begin
        wr_req        = 1'b1;
        wr_data.level = s_q8;
        wr_data.last  = scaled;
        res_value     = scaled;
      end
      default: ;
    endcase
    // channels past the end touch nothing and report zero
    if (!s1_inr_q) begin
      wr_req      = 1'b0;
      res_value   = '0;
      res_changed = 1'b0;
    end
  end

  assign wr_en = s1_vld_q && en && wr_req;

  // ---------------- stage registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_q     <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
      if (en) begin
        s1_vld_q <= accept;
        // forward the write that lands while this item reads the same entry
        byp_q    <= accept && wr_en && (in_addr == s1_addr_q);
      end else begin
        byp_q    <= 1'b0;
      end
      if (en) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_addr_q   <= in_addr;
      s1_inr_q    <= in_inr;
      s1_sample_q <= in_i.raw_sample;
      s1_func_q   <= acs_pkg::func_e'(in_i.func);
      byp_data_q  <= wr_data;
      if (s1_vld_q) begin
        out_value_q   <= res_value;
        out_changed_q <= res_changed;
      end
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.level_value = out_value_q;
  assign out_o.changed     = out_changed_q;

  // ---------------- assertions ----------------
  // a stalled compute stage keeps its item
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !en) |=> s1_vld_q)
    else $error("compute stage lost an item while stalled");

  // forwarding only follows a write in the cycle before
  a_byp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> $past(wr_en))
    else $error("forwarded entry without a write");

  // a finished item always reaches the output register
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && en) |=> out_vld_q)
    else $error("result dropped at output register");

  // state is written only for a real item on an existing channel
  a_wr_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (s1_vld_q && s1_inr_q))
    else $error("state write without a valid item");

endmodule

FILE: hw/rtl/acs_ram.sv
`timescale 1ns / 1ps

module acs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
